@@ hdl/assert_macros.svh @@
// Assertion macros used by the top level of the neighbor table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with asynchronous active-low reset disable.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication shorthand: antecedent holds in the same cycle.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ hdl/ntre_pkg.sv @@
// Package: types, codes and helpers of the neighbor table.
`default_nettype none
package ntre_pkg;

  typedef enum logic [1:0] {
    CMD_OBSERVE = 2'd0,
    CMD_AGE     = 2'd1,
    CMD_READ    = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_UPDATED   = 4'd0,
    ST_INSERTED  = 4'd1,
    ST_EVICTED   = 4'd2,
    ST_WEAK      = 4'd3,
    ST_INVALID   = 4'd4,
    ST_SELF      = 4'd5,
    ST_READ_OK   = 4'd6,
    ST_READ_MISS = 4'd7,
    ST_AGED      = 4'd8,
    ST_CLEARED   = 4'd9
  } status_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_RSSI_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_TTL_SECONDS    = 2'd1;
  localparam logic [1:0] CFG_OWN_ADDRESS    = 2'd2;

  localparam int unsigned CFG_WIDTH = 48;
  localparam logic [31:0] MS_PER_S  = 32'd1000;

  localparam logic signed [7:0] RESET_THRESHOLD = -8'sd70;
  localparam logic [15:0]       RESET_TTL       = 16'd30;

  typedef struct packed {
    logic [1:0]        command;
    logic [47:0]       mac;
    logic signed [7:0] rssi;
    logic [31:0]       now_ms;
    logic [63:0]       genome_upper;
    logic [63:0]       genome_lower;
    logic [7:0]        stage;
    logic [7:0]        level_byte;
    logic [7:0]        flag_byte;
    logic              genome_ok;
    logic [2:0]        index;
  } req_t;

  typedef struct packed {
    logic [3:0]        status;
    logic [3:0]        entry_count;
    logic [47:0]       out_mac;
    logic signed [7:0] out_rssi;
    logic [63:0]       out_genome_upper;
    logic [63:0]       out_genome_lower;
    logic [7:0]        out_stage;
    logic [7:0]        out_level;
    logic [7:0]        out_flags;
    logic [31:0]       out_last_seen;
  } rsp_t;

  // One table entry as held in the memory
  typedef struct packed {
    logic [47:0]       mac;
    logic signed [9:0] acc;
    logic [63:0]       gen_upper;
    logic [63:0]       gen_lower;
    logic [7:0]        stage;
    logic [7:0]        level;
    logic [7:0]        flags;
    logic [31:0]       last_seen;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_req;
    logic res_drop;
    logic res_clear;
    logic walk_start;
    logic walk_step;
    logic age_mode;
    logic commit;
    logic age_fin;
    logic read_issue;
    logic read_take;
    logic out_load;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] command;
    logic       drop;
    logic       walk_done;
    logic       slot_free;
  } sts_t;

  // Quarter-dBm accumulator to dBm, truncating toward zero
  function automatic logic signed [7:0] smoothed(input logic signed [9:0] acc);
    logic signed [9:0] t;
    t = acc + (acc[9] ? 10'sd3 : 10'sd0);
    return t[9:2];
  endfunction

  // acc + (4*rssi - acc)/4 with truncating division
  function automatic logic signed [9:0] ema(input logic signed [9:0] acc,
                                            input logic signed [7:0] rssi);
    logic signed [10:0] d;
    logic signed [10:0] d4;
    d  = $signed({rssi[7], rssi, 2'b00}) - $signed({acc[9], acc});
    d4 = d + (d[10] ? 11'sd3 : 11'sd0);
    // quotient is sign-extended back to the accumulator width
    return acc + $signed({d4[10], d4[10:2]});
  endfunction

endpackage
`default_nettype wire

@@ hdl/ntre_ctrl.sv @@
// Controller state machine of the neighbor table.
`default_nettype none
module ntre_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire ntre_pkg::sts_t sts_i,
  output ntre_pkg::ctl_t     ctl_o
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_DECODE  = 7'b0000010,
    S_SCAN    = 7'b0000100,
    S_AGE     = 7'b0001000,
    S_RD_ADDR = 7'b0010000,
    S_RD_DATA = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load_req = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        case (ntre_pkg::cmd_e'(sts_i.command))
          ntre_pkg::CMD_OBSERVE: begin
            if (sts_i.drop) begin
              ctl_o.res_drop = 1'b1;
              state_d        = S_DONE;
            end else begin
              ctl_o.walk_start = 1'b1;
              state_d          = S_SCAN;
            end
          end
          ntre_pkg::CMD_AGE: begin
            ctl_o.walk_start = 1'b1;
            state_d          = S_AGE;
          end
          ntre_pkg::CMD_READ: state_d = S_RD_ADDR;
          default: begin
            ctl_o.res_clear = 1'b1;
            state_d         = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        ctl_o.walk_step = 1'b1;
        if (sts_i.walk_done) begin
          ctl_o.commit = 1'b1;
          state_d      = S_DONE;
        end
      end
      S_AGE: begin
        ctl_o.walk_step = 1'b1;
        ctl_o.age_mode  = 1'b1;
        if (sts_i.walk_done) begin
          ctl_o.age_fin = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_RD_ADDR: begin
        ctl_o.read_issue = 1'b1;
        state_d          = S_RD_DATA;
      end
      S_RD_DATA: begin
        ctl_o.read_take = 1'b1;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (sts_i.slot_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

@@ hdl/ntre_datapath.sv @@
// Datapath of the neighbor table: config, entry memory, walk logic, result.
`default_nettype none
module ntre_datapath #(
  parameter int unsigned TABLE_DEPTH = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire ntre_pkg::req_t         in_req_i,
  input  wire logic                   cfg_we_i,
  input  wire logic [1:0]             cfg_index_i,
  input  wire logic [ntre_pkg::CFG_WIDTH-1:0] cfg_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output ntre_pkg::rsp_t              out_rsp_o,
  input  wire ntre_pkg::ctl_t         ctl_i,
  output ntre_pkg::sts_t              sts_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  // Configuration registers
  logic signed [7:0] thr_q;
  logic [15:0]       ttl_q;
  logic [47:0]       own_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ntre_pkg::RESET_THRESHOLD;
      ttl_q <= ntre_pkg::RESET_TTL;
      own_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ntre_pkg::CFG_RSSI_THRESHOLD: thr_q <= cfg_data_i[7:0];
        ntre_pkg::CFG_TTL_SECONDS:    ttl_q <= cfg_data_i[15:0];
        ntre_pkg::CFG_OWN_ADDRESS:    own_q <= cfg_data_i[47:0];
        default: ;
      endcase
    end
  end

  // Latched request
  ntre_pkg::req_t req_q;
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_req) begin
      req_q <= in_req_i;
    end
  end

  logic is_weak, is_self, drop;
  assign is_weak = ($signed(req_q.rssi) < thr_q);
  assign is_self = (req_q.mac == own_q);
  assign drop    = is_weak || !req_q.genome_ok || is_self;

  // Entry memory, one write and one registered read port
  ntre_pkg::entry_t mem_q [TABLE_DEPTH];
  ntre_pkg::entry_t rd_q;
  logic [AW-1:0]    rd_addr;
  logic             we;
  logic [AW-1:0]    wa;
  ntre_pkg::entry_t wd;

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr];
    if (we) begin
      mem_q[wa] <= wd;
    end
  end

  // Walk state
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      ptr_q;
  logic               pend_q;
  logic [AW-1:0]      pidx_q;
  logic [CW-1:0]      w_q;
  logic               hit_q;
  logic [AW-1:0]      hit_idx_q;
  logic signed [9:0]  hit_acc_q;
  logic [AW-1:0]      vic_q;
  logic [31:0]        vic_age_q;
  logic signed [7:0]  vic_sm_q;

  logic               issue;
  logic [31:0]        age;
  logic signed [7:0]  rd_sm;
  logic [31:0]        limit;
  logic               keep;
  logic               worse;

  assign issue   = ctl_i.walk_step && (ptr_q < count_q);
  assign rd_addr = ctl_i.read_issue ? AW'(req_q.index) : ptr_q[AW-1:0];
  assign age     = req_q.now_ms - rd_q.last_seen;
  assign rd_sm   = ntre_pkg::smoothed(rd_q.acc);
  assign limit   = 32'(ttl_q) * ntre_pkg::MS_PER_S;
  assign keep    = (age < limit);
  assign worse   = (pidx_q == '0) || (age > vic_age_q) ||
                   ((age == vic_age_q) && (rd_sm < vic_sm_q));

  // Commit of an observation
  logic [AW-1:0]     cidx;
  logic signed [9:0] cacc;
  logic              room;
  assign room = (count_q < DepthC);
  always_comb begin
    if (hit_q) begin
      cidx = hit_idx_q;
    end else if (room) begin
      cidx = count_q[AW-1:0];
    end else begin
      cidx = vic_q;
    end
    cacc = hit_q ? ntre_pkg::ema(hit_acc_q, req_q.rssi)
                 : $signed({req_q.rssi, 2'b00});
  end

  // Memory write select
  always_comb begin
    we = 1'b0;
    wa = w_q[AW-1:0];
    wd = rd_q;
    if (ctl_i.commit) begin
      we           = 1'b1;
      wa           = cidx;
      wd.mac       = req_q.mac;
      wd.acc       = cacc;
      wd.gen_upper = req_q.genome_upper;
      wd.gen_lower = req_q.genome_lower;
      wd.stage     = req_q.stage;
      wd.level     = req_q.level_byte;
      wd.flags     = req_q.flag_byte;
      wd.last_seen = req_q.now_ms;
    end else if (ctl_i.age_mode && pend_q && keep) begin
      we = 1'b1;
    end
  end

  // Walk control and table count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
      pend_q  <= 1'b0;
      w_q     <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (ctl_i.walk_start) begin
        ptr_q  <= '0;
        pend_q <= 1'b0;
        w_q    <= '0;
        hit_q  <= 1'b0;
      end else if (ctl_i.walk_step) begin
        pend_q <= issue;
        if (issue) begin
          ptr_q <= ptr_q + 1'b1;
        end
        if (pend_q && !ctl_i.age_mode && !hit_q && (rd_q.mac == req_q.mac)) begin
          hit_q <= 1'b1;
        end
        if (pend_q && ctl_i.age_mode && keep) begin
          w_q <= w_q + 1'b1;
        end
      end
      if (ctl_i.commit && !hit_q && room) begin
        count_q <= count_q + 1'b1;
      end else if (ctl_i.age_fin) begin
        count_q <= w_q;
      end else if (ctl_i.res_clear) begin
        count_q <= '0;
      end
    end
  end

  // Walk payload: hit and victim trackers
  always_ff @(posedge clk_i) begin
    if (ctl_i.walk_step && issue) begin
      pidx_q <= ptr_q[AW-1:0];
    end
    if (ctl_i.walk_step && pend_q && !ctl_i.age_mode) begin
      if (!hit_q && (rd_q.mac == req_q.mac)) begin
        hit_idx_q <= pidx_q;
        hit_acc_q <= rd_q.acc;
      end
      if (worse) begin
        vic_q     <= pidx_q;
        vic_age_q <= age;
        vic_sm_q  <= rd_sm;
      end
    end
  end

  // Result register
  ntre_pkg::rsp_t res_q;
  ntre_pkg::rsp_t res_d;
  logic           res_load;
  logic [CW-1:0]  cnt_after;
  assign cnt_after = count_q + ((!hit_q && room) ? CW'(1) : CW'(0));
  assign res_load  = ctl_i.res_drop || ctl_i.res_clear || ctl_i.age_fin ||
                     ctl_i.commit || ctl_i.read_take;

  // Response of the finished request
  always_comb begin
    res_d = '0;
    if (ctl_i.res_drop) begin
      res_d.entry_count = 4'(count_q);
      if (is_weak) begin
        res_d.status = ntre_pkg::ST_WEAK;
      end else if (!req_q.genome_ok) begin
        res_d.status = ntre_pkg::ST_INVALID;
      end else begin
        res_d.status = ntre_pkg::ST_SELF;
      end
    end else if (ctl_i.res_clear) begin
      res_d.status = ntre_pkg::ST_CLEARED;
    end else if (ctl_i.age_fin) begin
      res_d.status      = ntre_pkg::ST_AGED;
      res_d.entry_count = 4'(w_q);
    end else if (ctl_i.commit) begin
      res_d.entry_count = 4'(cnt_after);
      res_d.out_rssi    = ntre_pkg::smoothed(cacc);
      if (hit_q) begin
        res_d.status = ntre_pkg::ST_UPDATED;
      end else if (room) begin
        res_d.status = ntre_pkg::ST_INSERTED;
      end else begin
        res_d.status = ntre_pkg::ST_EVICTED;
      end
    end else if (ctl_i.read_take) begin
      res_d.entry_count = 4'(count_q);
      if (8'(req_q.index) < 8'(count_q)) begin
        res_d.status           = ntre_pkg::ST_READ_OK;
        res_d.out_mac          = rd_q.mac;
        res_d.out_rssi         = rd_sm;
        res_d.out_genome_upper = rd_q.gen_upper;
        res_d.out_genome_lower = rd_q.gen_lower;
        res_d.out_stage        = rd_q.stage;
        res_d.out_level        = rd_q.level;
        res_d.out_flags        = rd_q.flags;
        res_d.out_last_seen    = rd_q.last_seen;
      end else begin
        res_d.status = ntre_pkg::ST_READ_MISS;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  // Output register
  logic           out_valid_q;
  ntre_pkg::rsp_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_rsp_o       = out_q;
  assign sts_o.command   = req_q.command;
  assign sts_o.drop      = drop;
  assign sts_o.walk_done = !pend_q && (ptr_q >= count_q);
  assign sts_o.slot_free = !out_valid_q || !out_stall_i;

endmodule
`default_nettype wire

@@ hdl/neighbor_table_rssi_ema.sv @@
// Top level of the neighbor table with smoothed RSSI and oldest-first eviction.
// Usage:
//  - Request channel: in_valid_i / in_stall_o carry one in_req_i per request
//    (observe, age, read, clear). A request is taken when valid is high and
//    stall is low; stall stays high while a request is in work.
//  - Response channel: out_valid_o / out_stall_i carry one out_rsp_o per
//    request, held in an output register until taken.
//  - Config: cfg_we_i writes register cfg_index_i with cfg_data_i; write only
//    while the block is idle.
//  - Observe and age walk the valid entries of the table one entry per cycle
//    through the single read port of the entry memory. One request is in
//    work at a time; the next is taken once the block is idle again.
//  - Reset empties the table and loads the config defaults.
//  - While the receiver stalls, the finished response waits in the output
//    register; the next request may already be taken and worked on, and its
//    response waits until the register frees.
`default_nettype none
`include "assert_macros.svh"
module neighbor_table_rssi_ema #(
  parameter int unsigned TABLE_DEPTH = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire ntre_pkg::req_t                 in_req_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output ntre_pkg::rsp_t                      out_rsp_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [1:0]                     cfg_index_i,
  input  wire logic [ntre_pkg::CFG_WIDTH-1:0] cfg_data_i
);

  ntre_pkg::ctl_t ctl;
  ntre_pkg::sts_t sts;
  logic           req_take;
  logic           rsp_read_ok;
  logic           rsp_no_entry;

  ntre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  ntre_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .ctl_i       (ctl),
    .sts_o       (sts)
  );

  // Helpers for the checks below
  assign req_take     = in_valid_i && !in_stall_o;
  assign rsp_read_ok  = (out_rsp_o.status == ntre_pkg::ST_READ_OK);
  assign rsp_no_entry = out_rsp_o.status inside {ntre_pkg::ST_WEAK, ntre_pkg::ST_INVALID,
                                                 ntre_pkg::ST_SELF, ntre_pkg::ST_AGED,
                                                 ntre_pkg::ST_CLEARED,
                                                 ntre_pkg::ST_READ_MISS};

  // A taken request keeps the block busy in the next cycle
  `ASSERT_CLK(a_busy_after_req, clk_i, rst_ni, req_take |=> in_stall_o, "not busy after request")

  // Entry fields other than the smoothed RSSI are zero except for a successful read; the MAC is checked
  `ASSERT_IMP(a_mac_zero, clk_i, rst_ni, out_valid_o && !rsp_read_ok, out_rsp_o.out_mac == '0, "mac set")

  // Smoothed RSSI is zero for drop, age, clear and read miss
  `ASSERT_IMP(a_rssi_zero, clk_i, rst_ni, out_valid_o && rsp_no_entry, out_rsp_o.out_rssi == '0, "rssi set")

  // Load into the output register only when it is free
  `ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, ctl.out_load, !out_valid_o || !out_stall_i, "overwritten")

endmodule
`default_nettype wire
